// ===== design/bilinear_pixel_sampler_defines.svh =====
// Assertion macros shared by the bilinear pixel sampler.
`ifndef BILINEAR_PIXEL_SAMPLER_DEFINES_SVH
`define BILINEAR_PIXEL_SAMPLER_DEFINES_SVH

// Same-cycle implication, reset masks the check.
`define BPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masks the check.
`define BPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bps_pkg.sv =====
// Types, sizes and codes shared by the bilinear pixel sampler modules.
`timescale 1ns / 1ps
package bps_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int FRAC_BITS  = 8;

    localparam int COORD_W = 16;
    localparam int PIX_W   = 8;
    localparam int VAL_W   = 16;
    localparam int DIM_W   = 9;
    localparam int INT_W   = COORD_W - FRAC_BITS;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    // one weight factor holds 0 .. 2^FRAC_BITS
    localparam int FAC_W  = FRAC_BITS + 1;
    localparam int WGT_W  = 2 * FRAC_BITS + 1;
    localparam int PROD_W = PIX_W + WGT_W;
    localparam int SUM_MIN_W = PIX_W + 2 * FRAC_BITS;
    localparam int SUM_W  = (SUM_MIN_W > FRAC_BITS + VAL_W) ? SUM_MIN_W : FRAC_BITS + VAL_W;

    // compare width covers the registers, the coordinates plus one, and the store limits
    localparam int CMP_A = (DIM_W > INT_W + 1) ? DIM_W : INT_W + 1;
    localparam int CMP_B = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                           $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
    localparam int CMP_W = (CMP_A > CMP_B) ? CMP_A : CMP_B;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef struct packed {
        logic               func;
        logic [COORD_W-1:0] x_coord;
        logic [COORD_W-1:0] y_coord;
        logic [PIX_W-1:0]   pixel_value;
    } t_in_req;

    typedef struct packed {
        logic [VAL_W-1:0] sample_value;
        logic             range_error;
    } t_out_req;

    typedef struct packed {
        logic       load_in;
        logic       wr_en;
        logic       issue_en;
        logic [1:0] corner;
        logic       acc_en;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic func;
        logic range_err;
    } t_dp_status;

endpackage

// ===== design/bps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bps_ctrl.sv =====
// Controller: request sequencing, corner reads and result handoff.
`timescale 1ns / 1ps
module bps_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  bps_pkg::t_dp_status i_status,
    output bps_pkg::t_dp_cmd    o_cmd
);
    import bps_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_WRITE = 5'b00010,
        S_ISSUE = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_corner, n_corner;
    logic       r_out_valid, n_out_valid;
    logic       accept;
    logic       out_free;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state  = r_state;
        n_corner = r_corner;
        o_cmd    = '0;
        o_cmd.corner = r_corner;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_in = 1'b1;
                    n_corner      = 2'd0;
                    if (i_status.range_err) begin
                        n_state = S_DONE;
                    end else if (i_status.func == FUNC_WRITE) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_ISSUE;
                    end
                end
            end
            S_WRITE: begin
                o_cmd.wr_en = 1'b1;
                n_state     = S_DONE;
            end
            S_ISSUE: begin
                // read one corner, fold in the corner read before it
                o_cmd.issue_en = 1'b1;
                o_cmd.acc_en   = (r_corner != 2'd0);
                n_corner       = r_corner + 2'd1;
                if (r_corner == 2'd3) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.acc_en = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_corner    <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_corner    <= n_corner;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== design/bps_datapath.sv =====
// Datapath: image size registers, range check, pixel store, blend accumulator.
`timescale 1ns / 1ps
module bps_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bps_pkg::t_in_req           i_in,
    input  logic                       i_cfg_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bps_pkg::DIM_W-1:0]  i_cfg_data,
    input  bps_pkg::t_dp_cmd           i_cmd,
    output bps_pkg::t_dp_status        o_status,
    output bps_pkg::t_out_req          o_out
);
    import bps_pkg::*;

    logic [DIM_W-1:0]     r_width, r_height;
    logic [INT_W-1:0]     r_x0, r_y0;
    logic [FRAC_BITS-1:0] r_fx, r_fy;
    logic [PIX_W-1:0]     r_pix;
    logic                 r_err;
    logic [WGT_W-1:0]     r_wgt;
    logic [SUM_W-1:0]     r_acc;
    t_out_req             r_out;

    logic [CMP_W-1:0] ext_w, ext_h, cfg_w, cfg_h;
    logic [CMP_W-1:0] in_x0, in_y0, lim_x, lim_y;
    logic             in_err;

    logic [INT_W-1:0]   col, row;
    logic [ADDR_W-1:0]  addr;
    logic [FAC_W-1:0]   wx, wy;
    logic [2*FAC_W-1:0] wprod;
    logic [PIX_W-1:0]   rdata;
    logic [PROD_W-1:0]  pprod;

    // extent in use is the smaller of register and store size
    assign cfg_w = CMP_W'(r_width);
    assign cfg_h = CMP_W'(r_height);
    assign ext_w = (cfg_w > CMP_W'(MAX_WIDTH))  ? CMP_W'(MAX_WIDTH)  : cfg_w;
    assign ext_h = (cfg_h > CMP_W'(MAX_HEIGHT)) ? CMP_W'(MAX_HEIGHT) : cfg_h;

    assign in_x0 = CMP_W'(i_in.x_coord[COORD_W-1:FRAC_BITS]);
    assign in_y0 = CMP_W'(i_in.y_coord[COORD_W-1:FRAC_BITS]);
    // a sample needs the column and row after the base one as well
    assign lim_x = (i_in.func == FUNC_SAMPLE) ? in_x0 + CMP_W'(1) : in_x0;
    assign lim_y = (i_in.func == FUNC_SAMPLE) ? in_y0 + CMP_W'(1) : in_y0;
    assign in_err = (lim_x >= ext_w) || (lim_y >= ext_h);

    assign o_status.func      = i_in.func;
    assign o_status.range_err = in_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_RESET;
            r_height <= DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // corner code: high bit steps the column, low bit the row
    assign col  = r_x0 + INT_W'(i_cmd.corner[1]);
    assign row  = r_y0 + INT_W'(i_cmd.corner[0]);
    assign addr = ADDR_W'(row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);

    assign wx    = i_cmd.corner[1] ? FAC_W'(r_fx) : FAC_W'(1 << FRAC_BITS) - FAC_W'(r_fx);
    assign wy    = i_cmd.corner[0] ? FAC_W'(r_fy) : FAC_W'(1 << FRAC_BITS) - FAC_W'(r_fy);
    assign wprod = (2*FAC_W)'(wx) * (2*FAC_W)'(wy);
    assign pprod = PROD_W'(rdata) * PROD_W'(r_wgt);

    bps_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (addr),
        .i_wdata (r_pix),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x0  <= i_in.x_coord[COORD_W-1:FRAC_BITS];
            r_y0  <= i_in.y_coord[COORD_W-1:FRAC_BITS];
            r_fx  <= i_in.x_coord[FRAC_BITS-1:0];
            r_fy  <= i_in.y_coord[FRAC_BITS-1:0];
            r_pix <= i_in.pixel_value;
            r_err <= in_err;
        end
        if (i_cmd.issue_en) begin
            r_wgt <= wprod[WGT_W-1:0];
        end
        // clear on capture so writes and errors give zero
        if (i_cmd.load_in) begin
            r_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= r_acc + SUM_W'(pprod);
        end
        if (i_cmd.out_load) begin
            r_out.sample_value <= r_acc[FRAC_BITS +: VAL_W];
            r_out.range_error  <= r_err;
        end
    end

    assign o_out = r_out;

endmodule

// ===== design/bilinear_pixel_sampler.sv =====
// Top level of the bilinear pixel sampler: controller, datapath and checks.
//
// Input channel (i_in_valid / o_in_stall / i_in) carries one request: a pixel
// write (func 0) at the integer column and row of the coordinates, or a
// sample (func 1) at Q8.8 coordinates. Each request gives one result on the
// output channel (o_out_valid / i_out_stall / o_out): the Q8.8 blend of the
// four neighbours, or 0 for writes; range_error flags a position or a 2x2
// neighbourhood outside the configured image, which then leaves the store
// alone and returns 0.
// A sample reads its four corners one after another through the single
// read port of the pixel store and takes no new request until its result
// is loaded into the output register. A write goes through a write step,
// a request with a range error straight to the result handoff.
// The block takes a new request while a finished result still waits; a
// stalled result holds, and the next result waits until it is taken.
// Reset sets width and height to 256 and empties the output; the pixel store
// is not cleared and reads anything until written. The configuration port is
// always ready; write it only while the block is idle.
`timescale 1ns / 1ps
`include "bilinear_pixel_sampler_defines.svh"
module bilinear_pixel_sampler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bps_pkg::t_in_req              i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bps_pkg::t_out_req             o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bps_pkg::DIM_W-1:0]     i_cfg_data
);
    import bps_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    bps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    bps_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out       (o_out)
    );

    `BPS_ASSERT_IMP(a_idle_quiet, i_clk, i_rst_n, !o_in_stall, !(cmd.wr_en || cmd.issue_en || cmd.acc_en), "datapath active while idle")
    `BPS_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "request not followed by busy")
    `BPS_ASSERT_IMP(a_valid_from_load, i_clk, i_rst_n, $rose(o_out_valid), $past(cmd.out_load), "result valid without load")
    `BPS_ASSERT_IMP(a_error_zero, i_clk, i_rst_n, o_out_valid && o_out.range_error, o_out.sample_value == '0, "range error with nonzero value")

endmodule
